/* sv/rws_pkg.sv */
// Shared types and constants for the roulette wheel selection block.
// No dependencies; imported by every module of the block.
package rws_pkg;

   localparam int FITNESS_W = 16;
   localparam int INDEX_W   = 6;
   localparam int COUNT_W   = 7;
   localparam int RAND_W    = 16;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_DRAW  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Control from the sequencer to the head unit
   typedef struct packed {
      logic load;      // start of an item: latch threshold, clear accumulator
      logic walk;      // ring rotates one place this cycle
      logic is_draw;   // item is a draw
      logic wr_enable; // item is a write with an index inside the store
   } head_ctrl_type;

endpackage

/* sv/rws_cell.sv */
// One cell of the fitness ring: holds one stored entry and passes it on.
// Depends on rws_pkg.
module rws_cell
   import rws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  logic [FITNESS_W-1:0] fit_next,
   output logic [FITNESS_W-1:0] fit_out
);

   logic [FITNESS_W-1:0] fit_ff, fit_in;

   always_comb begin
      fit_in = shift ? fit_next : fit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_ff <= '0;
      end else begin
         fit_ff <= fit_in;
      end
   end

   assign fit_out = fit_ff;

endmodule

/* sv/rws_head.sv */
// Head of the fitness ring: threshold multiply, running total, cumulative
// sum and compare, entry replacement. Depends on rws_pkg.
module rws_head
   import rws_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int DRAW_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  head_ctrl_type                      ctrl,
   input  logic [$clog2(MAX_ENTRIES)-1:0]     step,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]   active_n,
   input  logic [$clog2(MAX_ENTRIES)-1:0]     wr_index,
   input  logic [FITNESS_W-1:0]               wr_value,
   input  logic [DRAW_BITS-1:0]               draw_r,
   input  logic [FITNESS_W-1:0]               head_value,
   output logic [FITNESS_W-1:0]               wrap_value,
   output logic [$clog2(MAX_ENTRIES)-1:0]     res_index,
   output logic                               res_past
);

   localparam int IDX_W   = $clog2(MAX_ENTRIES);
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int TOTAL_W = FITNESS_W + IDX_W;
   localparam int THR_W   = TOTAL_W + DRAW_BITS;

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] cum_ff, cum_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   sel_ff, sel_in;

   logic               wr_hit;
   logic               active;
   logic [TOTAL_W-1:0] cum_sum;
   logic               reached;

   always_comb begin
      wr_hit  = ctrl.wr_enable && (step == wr_index);
      active  = CNT_W'(step) < active_n;
      cum_sum = cum_ff + TOTAL_W'(head_value);
      reached = {cum_sum, {DRAW_BITS{1'b0}}} >= thr_ff;
      // entry being written re-enters the ring with its new value
      wrap_value = wr_hit ? wr_value : head_value;
   end

   always_comb begin
      total_in = total_ff;
      cum_in   = cum_ff;
      thr_in   = thr_ff;
      found_in = found_ff;
      sel_in   = sel_ff;
      if (ctrl.load) begin
         thr_in   = THR_W'(draw_r * total_ff);
         cum_in   = '0;
         found_in = 1'b0;
         sel_in   = '0;
      end else if (ctrl.walk) begin
         if (wr_hit) begin
            total_in = total_ff - TOTAL_W'(head_value) + TOTAL_W'(wr_value);
         end
         if (ctrl.is_draw && active && !found_ff) begin
            cum_in = cum_sum;
            if (reached) begin
               found_in = 1'b1;
               sel_in   = step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         found_ff <= found_in;
      end
      cum_ff <= cum_in;
      thr_ff <= thr_in;
      sel_ff <= sel_in;
   end

   always_comb begin
      if (total_ff == '0) begin
         res_index = '0;
         res_past  = 1'b0;
      end else if (found_ff) begin
         res_index = sel_ff;
         res_past  = 1'b0;
      end else begin
         res_index = IDX_W'(active_n - CNT_W'(1));
         res_past  = 1'b1;
      end
   end

endmodule

/* sv/roulette_wheel_selection.sv */
// Roulette wheel selection: fitness table held in a rotating ring of cells.
// A draw is accepted in idle, then passes a threshold multiply state, one full ring
// rotation and a finish state, after which its result is registered; a write takes the
// same path. The next item is taken only back in idle, not while one is in flight;
// a result still held at finish stalls the block.
// Sync active-high reset clears table, total, output; entry_count resets to 1.
module roulette_wheel_selection
   import rws_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int DRAW_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [COUNT_W-1:0]   csr_entry_count,
   // input items
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [INDEX_W-1:0]   req_entry_index,
   input  logic [FITNESS_W-1:0] req_fitness_value,
   input  logic [RAND_W-1:0]    req_random_draw,
   // result items
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [INDEX_W-1:0]   rsp_selected_index,
   output logic                 rsp_ran_past_end
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   // ---------------------------------------------------------------------
   // Configuration: entry_count, clamped to 1..MAX_ENTRIES on use
   // ---------------------------------------------------------------------
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0]   active_n;

   assign csr_ready = 1'b1;

   always_comb begin
      count_in = (csr_valid && csr_ready) ? csr_entry_count : count_ff;
      if (count_ff == '0) begin
         active_n = CNT_W'(1);
      end else if (32'(count_ff) > 32'(MAX_ENTRIES)) begin
         active_n = CNT_W'(MAX_ENTRIES);
      end else begin
         active_n = CNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(1);
      end else begin
         count_ff <= count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   logic                 req_take;
   logic                 step_last;
   logic                 rsp_load;
   head_ctrl_type        ctrl;

   logic [IDX_W-1:0]     step_ff, step_in;
   logic                 op_ff, op_in;
   logic                 wr_ok_ff, wr_ok_in;
   logic [IDX_W-1:0]     wr_idx_ff, wr_idx_in;
   logic [FITNESS_W-1:0] wr_val_ff, wr_val_in;
   logic [DRAW_BITS-1:0] draw_ff, draw_in;

   assign req_take  = req_valid && req_ready;
   assign step_last = (step_ff == IDX_W'(MAX_ENTRIES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (step_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // a draw waits here until the output register is free
            if (op_ff == OP_WRITE || !rsp_valid || rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready      = 1'b0;
      ctrl.load      = 1'b0;
      ctrl.walk      = 1'b0;
      ctrl.is_draw   = (op_ff == OP_DRAW);
      ctrl.wr_enable = (op_ff == OP_WRITE) && wr_ok_ff;
      rsp_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_LOAD: begin
            ctrl.load = 1'b1;
         end
         ST_WALK: begin
            ctrl.walk = 1'b1;
         end
         ST_FINISH: begin
            rsp_load = (op_ff == OP_DRAW) && (!rsp_valid || rsp_ready);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // item capture and rotation step count
   always_comb begin
      op_in     = op_ff;
      wr_ok_in  = wr_ok_ff;
      wr_idx_in = wr_idx_ff;
      wr_val_in = wr_val_ff;
      draw_in   = draw_ff;
      step_in   = step_ff;
      if (req_take) begin
         op_in     = req_operation;
         wr_ok_in  = 32'(req_entry_index) < 32'(MAX_ENTRIES);
         wr_idx_in = IDX_W'(32'(req_entry_index));
         wr_val_in = req_fitness_value;
         // only the low DRAW_BITS bits of the draw count
         draw_in   = DRAW_BITS'(64'(req_random_draw));
      end
      if (ctrl.load) begin
         step_in = '0;
      end else if (ctrl.walk) begin
         step_in = step_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      op_ff     <= op_in;
      wr_ok_ff  <= wr_ok_in;
      wr_idx_ff <= wr_idx_in;
      wr_val_ff <= wr_val_in;
      draw_ff   <= draw_in;
   end

   // ---------------------------------------------------------------------
   // Ring of cells: during a walk every cell takes its right neighbor's
   // entry, so entry k sits in cell 0 at step k; the head feeds the last
   // cell, and a full rotation brings every entry back to its own cell.
   // ---------------------------------------------------------------------
   logic [FITNESS_W-1:0] ring_val [MAX_ENTRIES];
   logic [FITNESS_W-1:0] wrap_value;

   for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
      logic [FITNESS_W-1:0] fit_next;
      if (j == MAX_ENTRIES - 1) begin : g_tail
         assign fit_next = wrap_value;
      end else begin : g_body
         assign fit_next = ring_val[j+1];
      end
      rws_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (ctrl.walk),
         .fit_next (fit_next),
         .fit_out  (ring_val[j])
      );
   end

   logic [IDX_W-1:0] res_index;
   logic             res_past;

   rws_head #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .DRAW_BITS   (DRAW_BITS)
   ) u_head (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .step       (step_ff),
      .active_n   (active_n),
      .wr_index   (wr_idx_ff),
      .wr_value   (wr_val_ff),
      .draw_r     (draw_ff),
      .head_value (ring_val[0]),
      .wrap_value (wrap_value),
      .res_index  (res_index),
      .res_past   (res_past)
   );

   // ---------------------------------------------------------------------
   // Output register: holds a finished draw while the next item is taken
   // ---------------------------------------------------------------------
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic               rsp_past_ff, rsp_past_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_past_in  = rsp_past_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = INDEX_W'(32'(res_index));
         rsp_past_in  = res_past;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_past_ff  <= rsp_past_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_selected_index = rsp_index_ff;
   assign rsp_ran_past_end   = rsp_past_ff;

endmodule

/* tb/rws_checker.sv */
// Checker for the roulette wheel selection block: watches the three channels,
// keeps its own fitness table, predicts each draw and compares results.
// Depends on rws_pkg.
module rws_checker
   import rws_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int DRAW_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [COUNT_W-1:0]   csr_entry_count,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_operation,
   input  logic [INDEX_W-1:0]   req_entry_index,
   input  logic [FITNESS_W-1:0] req_fitness_value,
   input  logic [RAND_W-1:0]    req_random_draw,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [INDEX_W-1:0]   rsp_selected_index,
   input  logic                 rsp_ran_past_end,
   output int                   pending,
   output int                   fail_count
);

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               past_end;
   } pick_type;

   logic [FITNESS_W-1:0] fitness_table [MAX_ENTRIES];
   longint unsigned      fitness_sum;
   logic [COUNT_W-1:0]   entry_count;
   pick_type             expected_picks [$];

   // First entry whose running sum, scaled by 2^DRAW_BITS, reaches draw * total, no division.
   function automatic pick_type spin_wheel(input logic [RAND_W-1:0] draw);
      longint unsigned draw_mask;
      longint unsigned threshold;
      longint unsigned running;
      int              taking_part;
      int              i;
      pick_type        pick;
      draw_mask = (64'd1 << DRAW_BITS) - 64'd1;
      threshold = (longint'(draw) & draw_mask) * fitness_sum;
      if (entry_count == 0)
         taking_part = 1;
      else if (entry_count > MAX_ENTRIES)
         taking_part = MAX_ENTRIES;
      else
         taking_part = int'(entry_count);
      pick.index    = INDEX_W'(taking_part - 1);
      pick.past_end = 1'b1;
      running       = 0;
      if (fitness_sum == 0) begin
         pick.index    = '0;
         pick.past_end = 1'b0;
      end else begin
         for (i = 0; i < taking_part; i++) begin
            running += fitness_table[i];
            if (pick.past_end && (running << DRAW_BITS) >= threshold) begin
               pick.index    = INDEX_W'(i);
               pick.past_end = 1'b0;
            end
         end
      end
      return pick;
   endfunction

   always @(posedge clock) begin : watch
      pick_type want;
      int       k;
      if (reset) begin
         for (k = 0; k < MAX_ENTRIES; k++)
            fitness_table[k] = '0;
         fitness_sum = 0;
         entry_count = COUNT_W'(1);
         expected_picks.delete();
      end else begin
         // result first: it always belongs to an older item
         if (rsp_valid && rsp_ready) begin
            if (expected_picks.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual index %0d flag %0b",
                        $time, rsp_selected_index, rsp_ran_past_end);
               fail_count++;
            end else begin
               want = expected_picks.pop_front();
               if (rsp_selected_index !== want.index) begin
                  $display("%0t: selected_index expected %0d actual %0d",
                           $time, want.index, rsp_selected_index);
                  fail_count++;
               end
               if (rsp_ran_past_end !== want.past_end) begin
                  $display("%0t: ran_past_end expected %0b actual %0b",
                           $time, want.past_end, rsp_ran_past_end);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready)
            entry_count = csr_entry_count;
         if (req_valid && req_ready) begin
            if (req_operation == OP_WRITE) begin
               if (req_entry_index < MAX_ENTRIES) begin
                  fitness_sum = fitness_sum - fitness_table[req_entry_index]
                                + req_fitness_value;
                  fitness_table[req_entry_index] = req_fitness_value;
               end
            end else begin
               expected_picks = {expected_picks, spin_wheel(req_random_draw)};
            end
         end
      end
      pending = expected_picks.size();
   end

endmodule

/* tb/roulette_wheel_selection_tb.sv */
// Testbench top for roulette_wheel_selection: drives items and count writes,
// idles both channels at random and gives the verdict.
// Depends on rws_pkg, roulette_wheel_selection and rws_checker.
module roulette_wheel_selection_tb;
   import rws_pkg::*;

   localparam int MAX_ENTRIES   = 64;
   localparam int DRAW_BITS     = 16;
   // drain time covers one item's pass through the block; leave some slack
   localparam int DRAIN_CYCLES  = MAX_ENTRIES + 16;
   // ~2000 items at their worst-case time each, taken several times over
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 200;
   localparam int HOLD_CYCLES   = 800;

   logic                 clock;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [COUNT_W-1:0]   csr_entry_count;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_operation;
   logic [INDEX_W-1:0]   req_entry_index;
   logic [FITNESS_W-1:0] req_fitness_value;
   logic [RAND_W-1:0]    req_random_draw;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [INDEX_W-1:0]   rsp_selected_index;
   logic                 rsp_ran_past_end;

   int pending;          // draws still waiting for their result
   int fail_count;
   int cycle_count;
   int phase_num = -1;   // current random phase, -1 while directed
   bit quiet;            // no idling on either side
   bit hold_on;          // receiver held off for a long stretch

   roulette_wheel_selection #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .DRAW_BITS   (DRAW_BITS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_entry_count    (csr_entry_count),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_entry_index    (req_entry_index),
      .req_fitness_value  (req_fitness_value),
      .req_random_draw    (req_random_draw),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_selected_index (rsp_selected_index),
      .rsp_ran_past_end   (rsp_ran_past_end)
   );

   rws_checker #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .DRAW_BITS   (DRAW_BITS)
   ) pick_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_entry_count    (csr_entry_count),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_entry_index    (req_entry_index),
      .req_fitness_value  (req_fitness_value),
      .req_random_draw    (req_random_draw),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_selected_index (rsp_selected_index),
      .rsp_ran_past_end   (rsp_ran_past_end),
      .pending            (pending),
      .fail_count         (fail_count)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side: after each accepted item draw a random stall length, zero when quiet.
   // Ready is only decided at the falling edge, once per edge.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            stall_left = quiet ? 0 : $urandom_range(0, 15);
         @(negedge clock);
         if (hold_on) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Long hold-off during a gap-free phase: the block's output fills up,
   // so req_ready has to drop while the sender keeps offering.
   initial begin : hold_off
      hold_on = 1'b0;
      wait (phase_num == 2);
      @(posedge clock);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on = 1'b0;
   end

   // Offer one item after a random gap and return at the falling edge
   // following its acceptance. Valid stays up when there is no gap.
   task automatic send_item(input logic                 op,
                            input logic [INDEX_W-1:0]   idx,
                            input logic [FITNESS_W-1:0] fit,
                            input logic [RAND_W-1:0]    draw);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_entry_index   <= idx;
      req_fitness_value <= fit;
      req_random_draw   <= draw;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Count register write, only with the block idle: all draws answered,
   // then a full item time so a trailing write item has finished too.
   task automatic write_count(input logic [COUNT_W-1:0] count);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid       <= 1'b1;
      csr_entry_count <= count;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // fitness mix: zeros, full scale, small values and anything
   function automatic logic [FITNESS_W-1:0] pick_fitness();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return FITNESS_W'($urandom_range(0, 255));
         default: return FITNESS_W'($urandom);
      endcase
   endfunction

   function automatic logic [RAND_W-1:0] pick_draw();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return RAND_W'($urandom);
      endcase
   endfunction

   // One random phase: set the count, then a stream of writes and draws.
   // Writes mostly land inside the taking-part range; some hit any entry,
   // half of those with zero so stray entries get cleaned up again.
   task automatic run_phase(input logic [COUNT_W-1:0] count, input int items);
      int taking_part;
      write_count(count);
      if (count == 0)
         taking_part = 1;
      else if (count > MAX_ENTRIES)
         taking_part = MAX_ENTRIES;
      else
         taking_part = int'(count);
      repeat (items) begin
         if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 9) == 0)
               send_item(OP_WRITE, INDEX_W'($urandom),
                         $urandom_range(0, 1) ? pick_fitness() : '0, RAND_W'($urandom));
            else
               send_item(OP_WRITE, INDEX_W'($urandom_range(0, taking_part - 1)),
                         pick_fitness(), RAND_W'($urandom));
         end else begin
            send_item(OP_DRAW, INDEX_W'($urandom), FITNESS_W'($urandom), pick_draw());
         end
      end
   endtask

   initial begin : stimulus
      logic [COUNT_W-1:0] phase_counts [RANDOM_PHASES];
      int                 p;
      reset             = 1'b1;
      csr_valid         = 1'b0;
      csr_entry_count   = '0;
      req_valid         = 1'b0;
      req_operation     = OP_WRITE;
      req_entry_index   = '0;
      req_fitness_value = '0;
      req_random_draw   = '0;
      quiet             = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // count is 1 out of reset; empty table gives index 0, no flag
      send_item(OP_DRAW, '0, '0, 16'h8000);
      send_item(OP_WRITE, 6'd0, 16'hFFFF, '0);
      send_item(OP_DRAW, '0, '0, 16'hFFFF);

      // four entries with zeros between; smallest and largest draws
      write_count(7'd4);
      send_item(OP_WRITE, 6'd0, 16'h0000, '0);
      send_item(OP_WRITE, 6'd1, 16'h0100, '0);
      send_item(OP_WRITE, 6'd2, 16'h0000, '0);
      send_item(OP_WRITE, 6'd3, 16'h0080, '0);
      send_item(OP_DRAW, '0, '0, 16'h0000);
      send_item(OP_DRAW, '0, '0, 16'h0001);
      send_item(OP_DRAW, '0, '0, 16'hFFFF);
      // weight outside the selection: the walk can run off the end
      send_item(OP_WRITE, 6'd63, 16'hFFFF, '0);
      send_item(OP_DRAW, '0, '0, 16'hFFFF);
      send_item(OP_DRAW, '0, '0, 16'h2000);
      send_item(OP_WRITE, 6'd63, 16'h0000, '0);

      // count of zero acts as one; entry 0 is empty here
      write_count(7'd0);
      send_item(OP_DRAW, '0, '0, 16'h4000);
      send_item(OP_DRAW, '0, '0, 16'h0000);

      // count above the table size acts as the full table
      write_count(7'd127);
      send_item(OP_WRITE, 6'd63, 16'h0001, '0);
      send_item(OP_DRAW, '0, '0, 16'hFFFF);
      send_item(OP_DRAW, '0, '0, 16'h0000);

      phase_counts = '{7'd64, 7'd1, 7'd64, 7'd2, 7'd0, 7'd65, 7'd0, 7'd127, 7'd0, 7'd64};
      phase_counts[4] = COUNT_W'($urandom_range(1, 64));
      phase_counts[8] = COUNT_W'($urandom_range(0, 127));
      for (p = 0; p < RANDOM_PHASES; p++) begin
         phase_num = p;
         // every third phase runs without gaps; phase 2 carries the hold-off
         quiet = (p % 3 == 2);
         run_phase(phase_counts[p], PHASE_ITEMS);
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
